@@ rtl/sha_pkg.sv @@
// Package: SHA-256 constants, a rotate function and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam logic [31:0] C_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] C_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'h38;

    // byte source selects for the block buffer write
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    typedef struct packed {
        logic       byte_wr;     // write one byte into the block
        logic [1:0] byte_sel;
        logic [5:0] byte_pos;
        logic       count_inc;   // bit_count += 8
        logic       load_work;   // chain -> working, start of a block
        logic       round_en;    // one compression round
        logic [5:0] round;
        logic       chain_add;   // chain += working
        logic       restart;     // chain <- IV, count <- 0
        logic [2:0] out_sel;     // digest word to present
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;         // bits 8..3 of bit_count
    } t_sts;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int n);
        f_rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha_dp.sv @@
// Datapath: block buffer, rolling schedule, round registers, chaining words, bit count.
`timescale 1ns / 1ps
`default_nettype none
module sha_dp
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output      t_sts        o_sts,
    output      logic [31:0] o_word
);
    logic [31:0] r_blk [16];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [63:0] r_cnt;

    logic [7:0]  wr_byte;
    logic [31:0] w_t, s0, s1, t1, t2, e_s, a_s, ch, maj;
    logic [5:0]  rnd;
    logic [3:0]  wi;

    assign o_sts.pos = r_cnt[8:3];
    assign rnd = i_cmd.round;
    assign wi  = rnd[3:0];

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: wr_byte = i_data_byte;
            SEL_PAD:  wr_byte = C_PAD_BYTE;
            SEL_ZERO: wr_byte = 8'h00;
            SEL_LEN:  wr_byte = r_cnt[8'(63 - 8 * i_cmd.byte_pos[2:0]) -: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    always_comb begin
        s1 = f_rotr(r_w[4'(wi - 4'd2)], 17) ^ f_rotr(r_w[4'(wi - 4'd2)], 19)
           ^ (r_w[4'(wi - 4'd2)] >> 10);
        s0 = f_rotr(r_w[4'(wi - 4'd15)], 7) ^ f_rotr(r_w[4'(wi - 4'd15)], 18)
           ^ (r_w[4'(wi - 4'd15)] >> 3);
        if (rnd < 6'd16) w_t = r_w[wi];
        else w_t = s1 + r_w[4'(wi - 4'd7)] + s0 + r_w[wi];
        e_s = f_rotr(r_v[4], 6) ^ f_rotr(r_v[4], 11) ^ f_rotr(r_v[4], 25);
        a_s = f_rotr(r_v[0], 2) ^ f_rotr(r_v[0], 13) ^ f_rotr(r_v[0], 22);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + e_s + ch + C_K[rnd] + w_t;
        t2  = a_s + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr)
            r_blk[i_cmd.byte_pos[5:2]][8'(31 - 8 * i_cmd.byte_pos[1:0]) -: 8] <= wr_byte;
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            for (int i = 0; i < 16; i++) r_w[i] <= r_blk[i];
        end else if (i_cmd.round_en) begin
            r_w[wi] <= w_t;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= C_IV[i];
            r_cnt <= '0;
        end else begin
            if (i_cmd.chain_add)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (i_cmd.count_inc) r_cnt <= r_cnt + 64'd8;
        end
    end

    assign o_word = r_h[i_cmd.out_sel];
endmodule
`default_nettype wire

@@ rtl/sha_ctrl.sv @@
// Controller: byte intake, padding sequence, round counter and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic        i_end_of_message,
    input  wire t_sts        i_sts,
    output      t_cmd        o_cmd,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [2:0]  o_word_index,
    output      logic        o_last_word
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_st, n_st;
    logic [5:0] r_rnd, n_rnd;
    logic [5:0] r_pp, n_pp;      // padding write position
    logic       r_fin, n_fin;    // message ended: padding pending
    logic       r_len, n_len;    // current pad block carries the length
    logic [2:0] r_oi, n_oi;
    logic       acc;

    assign o_stall = (r_st != ST_IDLE);
    assign acc = i_valid && !o_stall;
    assign o_valid = (r_st == ST_OUT);
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);

    always_comb begin
        n_st = r_st; n_rnd = r_rnd; n_pp = r_pp; n_fin = r_fin; n_len = r_len; n_oi = r_oi;
        o_cmd = '0;
        o_cmd.round = r_rnd;
        o_cmd.out_sel = r_oi;
        o_cmd.byte_pos = i_sts.pos;
        case (r_st)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.byte_wr = 1'b1;
                    o_cmd.byte_sel = SEL_DATA;
                    o_cmd.count_inc = 1'b1;
                    n_fin = i_end_of_message;
                    n_pp = 6'(i_sts.pos + 6'd1);
                    n_len = 1'b0;
                    if (i_sts.pos == 6'h3f) begin
                        n_st = ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_st = ST_PAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_rnd = '0;
                n_st = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_rnd = 6'(r_rnd + 6'd1);
                if (r_rnd == 6'd63) n_st = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.chain_add = 1'b1;
                if (r_fin && r_len) begin
                    n_oi = '0;
                    n_st = ST_OUT;
                end else if (r_fin) begin
                    // length not written: pad one more block (and the marker if not yet placed)
                    n_st = ST_PAD;
                    n_len = (i_sts.pos >= C_LEN_POS);
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_PAD: begin
                // writes 0x80 at the message end if due, zeros, then the length bytes if they fit
                o_cmd.byte_wr = 1'b1;
                o_cmd.byte_pos = r_pp;
                if (!r_len && r_pp == i_sts.pos) o_cmd.byte_sel = SEL_PAD;
                else if (r_pp >= C_LEN_POS && i_sts.pos < C_LEN_POS)
                    o_cmd.byte_sel = SEL_LEN;
                else if (r_pp >= C_LEN_POS && i_sts.pos >= C_LEN_POS && r_len)
                    o_cmd.byte_sel = SEL_LEN;
                else o_cmd.byte_sel = SEL_ZERO;
                n_pp = 6'(r_pp + 6'd1);
                if (r_pp == 6'h3f) begin
                    n_st = ST_LOAD;
                    n_len = r_len || (i_sts.pos < C_LEN_POS);
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oi = 3'(r_oi + 3'd1);
                    if (r_oi == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_fin = 1'b0;
                        n_st = ST_IDLE;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_rnd <= '0; r_pp <= '0;
            r_fin <= 1'b0; r_len <= 1'b0; r_oi <= '0;
        end else begin
            r_st <= n_st; r_rnd <= n_rnd; r_pp <= n_pp;
            r_fin <= n_fin; r_len <= n_len; r_oi <= n_oi;
        end
    end
endmodule
`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
// Top level: SHA-256 byte-stream hasher with digest word output.
//   channel | dir | words               | handshake
//   input   | in  | data_byte, end flag | i_valid / o_stall
//   output  | out | 8 digest words      | o_valid / i_stall
// A byte that does not fill a block is simply stored; a full block runs a compression
// (load, 64 rounds of the single round unit, chain add).
// The final byte pads to the block end at one byte a cycle,
// runs one or two compressions, then shows 8 words, one per unstalled cycle.
// Reset is synchronous: chain words return to the initial hash, count to zero.
// The input stalls for the whole of padding, a compression and the digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [31:0] o_digest_word,
    output      logic [2:0]  o_word_index,
    output      logic        o_last_word
);
    t_cmd cmd;
    t_sts sts;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_end_of_message,
        .i_sts(sts), .o_cmd(cmd), .o_valid, .i_stall, .o_word_index, .o_last_word
    );

    sha_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_data_byte, .o_sts(sts), .o_word(o_digest_word)
    );

    a_no_accept_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while digest shown");
    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=> o_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest word index did not advance");
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_digest_word)) else $error("stalled digest word changed");
endmodule
`default_nettype wire

@@ tb/sv/sha256_digest_checker.sv @@
// Checker: watches both channels, predicts SHA-256 digests and compares them.
`timescale 1ns / 1ps
`default_nettype none
module sha256_digest_checker
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    input  wire logic        i_o_valid,
    input  wire logic        i_stall,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_word_index,
    input  wire logic        i_last_word,
    output      int          o_fail_count,
    output      int          o_pending,
    output      int          o_words_seen
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [63:0]  msg_bits;
    t_digest_word digest_queue [$];

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, a, b;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                a = w[(t-2) & 15];
                b = w[(t-15) & 15];
                wt = (rr(a, 17) ^ rr(a, 19) ^ (a >> 10)) + w[(t-7) & 15]
                   + (rr(b, 7) ^ rr(b, 18) ^ (b >> 3)) + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + C_K[t] + wt;
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic eom);
        int pos;
        t_digest_word d;
        pos = msg_bits[8:3];
        msg_block[pos] = data;
        msg_bits += 64'd8;
        if (pos == 63) compress_block();
        if (eom) begin
            pos = msg_bits[8:3];
            msg_block[pos] = C_PAD_BYTE;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                d.word  = hash_state[i];
                d.index = 3'(i);
                d.last  = (i == 7);
                digest_queue.push_back(d);
            end
            for (int i = 0; i < 8; i++) hash_state[i] = C_IV[i];
            msg_bits = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_state[i] = C_IV[i];
            msg_bits = '0;
            digest_queue.delete();
        end else begin
            if (i_valid && !i_o_stall) absorb_byte(i_data_byte, i_end_of_message);
            if (i_o_valid && !i_stall) begin
                o_words_seen <= o_words_seen + 1;
                if (digest_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected digest word %h idx %0d", i_digest_word, i_word_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = digest_queue.pop_front();
                    if (exp_w != {i_digest_word, i_word_index, i_last_word}) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                exp_w.word, exp_w.index, exp_w.last,
                                i_digest_word, i_word_index, i_last_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= digest_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_words_seen = 0;
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench top: byte stimulus, output stall pattern and verdict for the hasher.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, in_eom = 0, out_stall = 0;
    logic [7:0]  in_byte = 0;
    logic        dut_stall, out_valid, out_last;
    logic [31:0] out_word;
    logic [2:0]  out_index;
    int          fail_count, pending, words_seen;
    int          bytes_sent = 0, msgs_sent = 0;
    bit          calm = 0, hold_long = 0;

    sha256_stream_hasher dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(dut_stall),
        .i_data_byte(in_byte), .i_end_of_message(in_eom), .o_valid(out_valid),
        .i_stall(out_stall), .o_digest_word(out_word), .o_word_index(out_index),
        .o_last_word(out_last)
    );

    sha256_digest_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_o_stall(dut_stall),
        .i_data_byte(in_byte), .i_end_of_message(in_eom), .i_o_valid(out_valid),
        .i_stall(out_stall), .i_digest_word(out_word), .i_word_index(out_index),
        .i_last_word(out_last), .o_fail_count(fail_count), .o_pending(pending),
        .o_words_seen(words_seen)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // offer one byte and hold it until accepted; random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1;
        in_byte  <= b;
        in_eom   <= eom;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        bytes_sent++;
        if (eom) msgs_sent++;
    endtask

    task automatic send_message(input int len, input int pattern);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver stalls in bursts; one long hold-off while messages keep coming
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_long) begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                out_stall <= 0;
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    initial begin
        int len;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: single bytes of extremes, padding boundary lengths
        send_message(1, 0);
        send_message(1, 1);
        send_message(55, 2);
        send_message(56, 1);
        drain();
        send_message(64, 2);
        drain();
        hold_long = 1;
        send_message(3, 2);
        send_message(2, 2);
        send_message(4, 2);
        drain();
        // random messages, mostly short
        while (bytes_sent < 370) begin
            if (bytes_sent > 300) calm = 1;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130) : $urandom_range(1, 12);
            if (len > 370 - bytes_sent) len = 370 - bytes_sent;
            send_message(len, 2);
        end
        drain();
        repeat (200) @(posedge clk);
        $display("sent %0d bytes in %0d messages, checked %0d digest words",
            bytes_sent, msgs_sent, words_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire
